>>> src/assert_macros.svh
// Assertion macros used by the integer-to-radix-digits back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, switched off during reset.
`define ITRD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check sampled on the rising clock edge, active during reset too.
`define ITRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/itrd_pkg.sv
// Package with the shared types and constants of the radix digit converter.
package itrd_pkg;

  // Field widths fixed by the interface.
  localparam int RADIX_BITS = 5;
  localparam int DIGIT_BITS = 4;
  localparam int KIND_BITS  = 2;

  // Radix register reset value and the saturation limits of the base.
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = 1;
  localparam int Q_CNT_BITS  = 2;

  // Class of an accepted item, decided by the front.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_POS,
    KIND_ZERO,
    KIND_NEG
  } kind_t;

  // States of the back-end sequencer.
  typedef enum logic [2:0] {
    B_IDLE,
    B_SPECIAL,
    B_DIV,
    B_STORE,
    B_FETCH,
    B_LOAD
  } back_state_t;

endpackage

>>> src/itrd_front.sv
// Front end: holds the radix register, classifies each input beat and queues it.
module itrd_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [VALUE_BITS-1:0]           value,
  input  logic                                   cfg_wr_en,
  input  logic [itrd_pkg::RADIX_BITS-1:0]        cfg_wr_data,
  output logic                                   push_valid,
  input  logic                                   push_ready,
  output logic [itrd_pkg::KIND_BITS+itrd_pkg::RADIX_BITS+VALUE_BITS-2:0] push_data
);
  import itrd_pkg::*;

  localparam int MAG_BITS = VALUE_BITS - 1;

  logic [RADIX_BITS-1:0] radix;
  logic [RADIX_BITS-1:0] radix_eff;
  logic [MAG_BITS-1:0]   mag;
  kind_t                 kind;

  // Radix configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // Saturate the base into the range two to sixteen.
  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  // Classify the value by its sign bit and magnitude.
  always_comb begin
    mag = value[MAG_BITS-1:0];
    if (value[VALUE_BITS-1]) begin
      kind = KIND_NEG;
    end else if (mag == '0) begin
      kind = KIND_ZERO;
    end else begin
      kind = KIND_POS;
    end
  end

  // A beat passes straight into the queue whenever it has room.
  assign push_valid = in_valid;
  assign in_ready   = push_ready;
  assign push_data  = {kind, radix_eff, mag};

endmodule

>>> src/itrd_queue.sv
// Two-entry queue that decouples the front end from the conversion back end.
module itrd_queue #(
  parameter int WIDTH = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import itrd_pkg::*;

  logic [WIDTH-1:0]      entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic [Q_CNT_BITS-1:0] count_next;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != Q_CNT_BITS'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + Q_CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - Q_CNT_BITS'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/itrd_back.sv
// Back end: serial division by the radix, digit stack and output register.
`include "assert_macros.svh"

module itrd_back #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pop_valid,
  output logic                                   pop_ready,
  input  logic [itrd_pkg::KIND_BITS+itrd_pkg::RADIX_BITS+VALUE_BITS-2:0] pop_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [itrd_pkg::DIGIT_BITS-1:0]        digit,
  output logic                                   last_digit,
  output logic                                   negative_error
);
  import itrd_pkg::*;

  localparam int MAG_BITS   = VALUE_BITS - 1;
  localparam int ENTRY_BITS = KIND_BITS + RADIX_BITS + MAG_BITS;
  localparam int STEP_BITS  = $clog2(MAG_BITS);
  localparam int CNT_BITS   = $clog2(DIGIT_DEPTH + 1);
  localparam int ADDR_BITS  = $clog2(DIGIT_DEPTH);

  back_state_t state;
  back_state_t state_next;

  // Unpacked queue entry.
  kind_t                 in_kind;
  logic [RADIX_BITS-1:0] in_radix;
  logic [MAG_BITS-1:0]   in_mag;

  // Division datapath.
  logic [MAG_BITS-1:0]   quot;
  logic [DIGIT_BITS-1:0] rem;
  logic [RADIX_BITS-1:0] div_radix;
  logic [STEP_BITS-1:0]  step;
  logic [DIGIT_BITS:0]   shifted;
  logic [DIGIT_BITS:0]   diff;
  logic                  quot_bit;
  logic                  special_err;

  // Digit stack.
  logic [DIGIT_BITS-1:0] mem [DIGIT_DEPTH];
  logic [DIGIT_BITS-1:0] rd_data;
  logic [CNT_BITS-1:0]   cnt;
  logic [CNT_BITS-1:0]   cnt_inc;
  logic [CNT_BITS-1:0]   cnt_dec;
  logic                  stack_full;

  // Controls from the sequencer.
  logic                  slot_free;
  logic                  pop_ready_c;
  logic                  load_out;
  logic                  mem_we;
  logic                  rd_en;
  logic [DIGIT_BITS-1:0] out_digit_sel;
  logic                  out_last_sel;
  logic                  out_err_sel;

  assign in_kind  = kind_t'(pop_data[ENTRY_BITS-1 -: KIND_BITS]);
  assign in_radix = pop_data[MAG_BITS +: RADIX_BITS];
  assign in_mag   = pop_data[MAG_BITS-1:0];

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign shifted  = {rem, quot[MAG_BITS-1]};
  assign quot_bit = (shifted >= div_radix);
  assign diff     = shifted - div_radix;

  assign cnt_inc    = cnt + CNT_BITS'(1);
  assign cnt_dec    = cnt - CNT_BITS'(1);
  assign stack_full = (cnt_inc == CNT_BITS'(DIGIT_DEPTH));
  assign slot_free  = !out_valid || out_ready;
  assign pop_ready  = pop_ready_c;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          state_next = (in_kind == KIND_POS) ? B_DIV : B_SPECIAL;
        end
      end
      B_SPECIAL: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      B_DIV: begin
        if (step == '0) begin
          state_next = B_STORE;
        end
      end
      B_STORE: begin
        state_next = ((quot == '0) || stack_full) ? B_FETCH : B_DIV;
      end
      B_FETCH: begin
        state_next = B_LOAD;
      end
      B_LOAD: begin
        if (slot_free) begin
          state_next = (cnt == '0) ? B_IDLE : B_FETCH;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    pop_ready_c   = 1'b0;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    out_digit_sel = rd_data;
    out_last_sel  = (cnt == '0);
    out_err_sel   = 1'b0;
    case (state)
      B_IDLE: begin
        pop_ready_c = 1'b1;
      end
      B_SPECIAL: begin
        load_out      = slot_free;
        out_digit_sel = '0;
        out_last_sel  = 1'b1;
        out_err_sel   = special_err;
      end
      B_STORE: begin
        mem_we = 1'b1;
      end
      B_FETCH: begin
        rd_en = 1'b1;
      end
      B_LOAD: begin
        load_out = slot_free;
      end
      default: begin
        pop_ready_c = 1'b0;
      end
    endcase
  end

  // Sequencer state, output valid and digit count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == B_IDLE && pop_valid) begin
        cnt <= '0;
      end else if (mem_we) begin
        cnt <= cnt_inc;
      end else if (rd_en) begin
        cnt <= cnt_dec;
      end
    end
  end

  // Division datapath: load on pop, one quotient bit per cycle, restart per digit.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        quot        <= in_mag;
        rem         <= '0;
        div_radix   <= in_radix;
        step        <= STEP_BITS'(MAG_BITS - 1);
        special_err <= (in_kind == KIND_NEG);
      end
      B_DIV: begin
        quot <= {quot[MAG_BITS-2:0], quot_bit};
        rem  <= quot_bit ? diff[DIGIT_BITS-1:0] : shifted[DIGIT_BITS-1:0];
        step <= step - STEP_BITS'(1);
      end
      B_STORE: begin
        rem  <= '0;
        step <= STEP_BITS'(MAG_BITS - 1);
      end
      default: begin
        quot <= quot;
      end
    endcase
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      digit          <= out_digit_sel;
      last_digit     <= out_last_sel;
      negative_error <= out_err_sel;
    end
  end

  // Digit stack memory: remainders pushed, read back in reverse order.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt[ADDR_BITS-1:0]] <= rem;
    end
    if (rd_en) begin
      rd_data <= mem[cnt_dec[ADDR_BITS-1:0]];
    end
  end

  `ITRD_ASSERT(a_cnt_bound, clk, rst, (cnt <= CNT_BITS'(DIGIT_DEPTH)), "digit count overflow")
  `ITRD_ASSERT(a_rem_below_radix, clk, rst, (state == B_DIV) |-> ({1'b0, rem} < div_radix), "remainder not below radix")
  `ITRD_ASSERT(a_radix_range, clk, rst, (state == B_DIV) |-> ((div_radix >= RADIX_MIN) && (div_radix <= RADIX_MAX)), "radix outside two to sixteen")
  `ITRD_ASSERT(a_fetch_nonempty, clk, rst, (state == B_FETCH) |-> (cnt != '0), "pop from empty digit stack")
  `ITRD_ASSERT(a_last_ends_item, clk, rst, (load_out && out_last_sel) |=> (state == B_IDLE), "last digit loaded but sequencer busy")

endmodule

>>> src/integer_to_radix_digits.sv
// Flow: a positive value leaves the queue, then each of its digits takes VALUE_BITS - 1
//   division bit steps plus one stack write, and the digits drain through the fetch and
//   load states. Throughput: one item at a time in the back end, set by the
//   one-bit-per-cycle divider; a two-entry queue lets up to two further items be accepted.
// Zero and negative values give a single beat, loaded from the special state.
// Synchronous reset clears control state and sets the radix register to eight.
module integer_to_radix_digits #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [VALUE_BITS-1:0]    value,
  input  logic                            cfg_wr_en,
  input  logic [itrd_pkg::RADIX_BITS-1:0] cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itrd_pkg::DIGIT_BITS-1:0] digit,
  output logic                            last_digit,
  output logic                            negative_error
);
  import itrd_pkg::*;

  localparam int ENTRY_BITS = KIND_BITS + RADIX_BITS + VALUE_BITS - 1;

  logic                  push_valid;
  logic                  push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  // Front end: radix register and classification.
  itrd_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // Queue between front and back.
  itrd_queue #(
    .WIDTH (ENTRY_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: division, digit stack and output.
  itrd_back #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digit          (digit),
    .last_digit     (last_digit),
    .negative_error (negative_error)
  );

endmodule

>>> test/integer_to_radix_digits_test.sv
// Self-checking testbench for the integer to radix digit converter.
module integer_to_radix_digits_test;
  import itrd_pkg::*;

  // One expected output beat.
  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  last_digit;
    logic                  negative_error;
  } digit_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [31:0]    value;
  logic                  cfg_wr_en;
  logic [RADIX_BITS-1:0] cfg_wr_data;
  logic                  out_valid;
  logic                  out_ready;
  logic [DIGIT_BITS-1:0] digit;
  logic                  last_digit;
  logic                  negative_error;

  digit_beat_t           expected_digits[$];
  logic [RADIX_BITS-1:0] radix_setting;
  int unsigned           send_idle_pct;
  int unsigned           recv_stall_pct;
  int unsigned           error_count;

  integer_to_radix_digits #(
    .VALUE_BITS(32),
    .DIGIT_DEPTH(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digit(digit),
    .last_digit(last_digit),
    .negative_error(negative_error)
  );

  // The clock runs with a period of 8.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Prints one mismatch line, with printing capped, and counts it.
  task automatic report_mismatch(input string msg);
    if (error_count < 100) begin
      $display("%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Works out the digit beats that one value gives at the current radix.
  function automatic void predict_digits(input logic signed [31:0] v);
    logic [DIGIT_BITS-1:0] remainders[$];
    int unsigned           quotient;
    int unsigned           base;
    int                    i;
    digit_beat_t           beat;
    base = radix_setting;
    if (radix_setting < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_setting > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    // A negative value is rejected with a single error beat.
    if (v < 0) begin
      beat = '{digit: '0, last_digit: 1'b1, negative_error: 1'b1};
      expected_digits.push_back(beat);
      return;
    end
    quotient = v;
    if (quotient == 0) begin
      remainders.push_back('0);
    end
    while (quotient != 0) begin
      remainders.push_back(DIGIT_BITS'(quotient % base));
      quotient = quotient / base;
    end
    // Remainders come out in reverse, most significant digit first.
    for (i = remainders.size() - 1; i >= 0; i--) begin
      beat = '{digit: remainders[i], last_digit: (i == 0), negative_error: 1'b0};
      expected_digits.push_back(beat);
    end
  endfunction

  // Sends one value after a random gap and records its digits once accepted.
  task automatic send_value(input logic signed [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_digits(v);
  endtask

  // Stops sending and waits until every expected beat has come out.
  task automatic wait_until_idle();
    int unsigned cycles;
    cycles = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_digits.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    if (expected_digits.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", expected_digits.size()));
      expected_digits.delete();
    end
    repeat (40) @(posedge clk);
  endtask

  // Writes the radix register; only called while the block is idle.
  task automatic set_radix(input logic [RADIX_BITS-1:0] r);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    radix_setting = r;
  endtask

  // Random value, mostly positive with a random number of significant bits.
  function automatic logic signed [31:0] pick_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      return {1'b1, 31'($urandom)};
    end else if (pick < 27) begin
      return $urandom_range(0, 300);
    end
    return {1'b0, 31'($urandom) >> $urandom_range(0, 30)};
  endfunction

  // The receiver stalls at random with the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every accepted output beat is compared with the oldest expectation.
  always @(posedge clk) begin
    digit_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("beat with no expectation: digit %0d last %0b error %0b",
                                  digit, last_digit, negative_error));
      end else begin
        want = expected_digits.pop_front();
        if (digit !== want.digit) begin
          report_mismatch($sformatf("digit %0d, expected %0d", digit, want.digit));
        end
        if (last_digit !== want.last_digit) begin
          report_mismatch($sformatf("last_digit %0b, expected %0b",
                                    last_digit, want.last_digit));
        end
        if (negative_error !== want.negative_error) begin
          report_mismatch($sformatf("negative_error %0b, expected %0b",
                                    negative_error, want.negative_error));
        end
      end
    end
  end

  // Values at the reset radix of eight, including both sign extremes.
  task automatic test_reset_radix();
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(32'sd7);
    send_value(32'sd8);
    send_value(32'sh7fffffff);
    send_value(-32'sd1);
    send_value(32'sh80000000);
    wait_until_idle();
  endtask

  // Radix values outside two to sixteen saturate to the nearest limit.
  task automatic test_radix_saturation();
    set_radix(5'd0);
    send_value(32'sd5);
    wait_until_idle();
    set_radix(5'd1);
    send_value(32'sd6);
    wait_until_idle();
    set_radix(5'd17);
    send_value(32'sd255);
    wait_until_idle();
    set_radix(5'd31);
    send_value(32'sh12345678);
    wait_until_idle();
  endtask

  // Longest and shortest digit strings at the extreme and middle radixes.
  task automatic test_radix_extremes();
    set_radix(RADIX_MIN);
    send_value(32'sh7fffffff);
    send_value(32'sh40000000);
    send_value(32'sd1);
    wait_until_idle();
    set_radix(RADIX_MAX);
    send_value(32'sh7fffffff);
    send_value(32'sd15);
    send_value(32'sd16);
    send_value(32'sh5a5a5a5a);
    wait_until_idle();
    set_radix(5'd10);
    send_value(32'sd2147483647);
    send_value(32'sd0);
    send_value(32'sh80000000);
    wait_until_idle();
  endtask

  // One idling phase of random values, new radix at start and halfway.
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned count);
    int unsigned n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      if (n == 0 || n == count / 2) begin
        wait_until_idle();
        if ($urandom_range(0, 3) == 0) begin
          set_radix(RADIX_BITS'($urandom_range(0, 31)));
        end else begin
          set_radix(RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX)));
        end
      end
      send_value(pick_value());
    end
    wait_until_idle();
  endtask

  // Main sequence: reset, directed tests, then the random phases.
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    value          = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    out_ready      = 1'b0;
    radix_setting  = RADIX_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_radix();
    test_radix_saturation();
    test_radix_extremes();
    test_random_phase(0, 0, 28);
    test_random_phase(58, 0, 28);
    test_random_phase(0, 58, 28);
    test_random_phase(30, 30, 28);

    if (error_count == 0) begin
      $display("integer_to_radix_digits_test: clean");
    end else begin
      $display("integer_to_radix_digits_test: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #12000000;
    $display("integer_to_radix_digits_test: errors");
    $finish;
  end

endmodule

>>> integer_to_radix_digits.f
+incdir+src
src/itrd_pkg.sv
src/itrd_front.sv
src/itrd_queue.sv
src/itrd_back.sv
src/integer_to_radix_digits.sv
test/integer_to_radix_digits_test.sv
